[hdl/xmm_pkg.sv]
// ----------------------------------------------------------------------------
// xmm_pkg
// Types, constants and helper functions shared by the memory manager.
// ----------------------------------------------------------------------------
package xmm_pkg;

    localparam int HANDLE_COUNT       = 64;
    localparam int UPPER_BLOCKS       = 96;
    localparam int BLOCK_PARAGRAPHS   = 128;
    localparam int UPPER_BASE_SEGMENT = 49152;
    localparam int MAX_XMS_KB         = 8192;
    localparam int HMA_KB             = 64;

    localparam int CAP_PARAGRAPHS = UPPER_BLOCKS * BLOCK_PARAGRAPHS;
    localparam int HW  = $clog2(HANDLE_COUNT);
    localparam int UW  = $clog2(UPPER_BLOCKS);
    localparam int IW  = $clog2((HANDLE_COUNT > UPPER_BLOCKS ?
                                 HANDLE_COUNT : UPPER_BLOCKS) + 1);
    localparam int PW  = $clog2(CAP_PARAGRAPHS + 1);
    localparam int MW  = PW + 1;
    localparam int KW  = $clog2(MAX_XMS_KB + 1);
    localparam int LW  = (PW > 14 ? PW : 14) + 1;

    localparam int XMS_W = 14;
    localparam int UMB_W = 8;
    localparam int CFG_W = 14;

    localparam logic [MW-1:0] MARK_CHAIN = {{(MW-1){1'b1}}, 1'b0};

    localparam logic [1:0] CFG_XMS_LIMIT = 2'd0;
    localparam logic [1:0] CFG_UPPER_KB  = 2'd1;

    localparam logic [XMS_W-1:0] XMS_RESET = 14'd8192;
    localparam logic [UMB_W-1:0] UMB_RESET = 8'd192;

    localparam logic [7:0] CMD_VERSION     = 8'h00;
    localparam logic [7:0] CMD_HMA_REQ     = 8'h01;
    localparam logic [7:0] CMD_HMA_REL     = 8'h02;
    localparam logic [7:0] CMD_A20_GON     = 8'h03;
    localparam logic [7:0] CMD_A20_GOFF    = 8'h04;
    localparam logic [7:0] CMD_A20_LON     = 8'h05;
    localparam logic [7:0] CMD_A20_LOFF    = 8'h06;
    localparam logic [7:0] CMD_A20_QUERY   = 8'h07;
    localparam logic [7:0] CMD_FREE_QUERY  = 8'h08;
    localparam logic [7:0] CMD_ALLOC       = 8'h09;
    localparam logic [7:0] CMD_FREE_HANDLE = 8'h0A;
    localparam logic [7:0] CMD_UMB_REQ     = 8'h10;
    localparam logic [7:0] CMD_UMB_REL     = 8'h11;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_UNSUPPORTED = 4'd1;
    localparam logic [3:0] ST_NO_HMA      = 4'd2;
    localparam logic [3:0] ST_HMA_USED    = 4'd3;
    localparam logic [3:0] ST_HMA_FREE    = 4'd4;
    localparam logic [3:0] ST_NO_MEMORY   = 4'd5;
    localparam logic [3:0] ST_NO_HANDLE   = 4'd6;
    localparam logic [3:0] ST_BAD_HANDLE  = 4'd7;
    localparam logic [3:0] ST_SMALLER     = 4'd8;
    localparam logic [3:0] ST_NO_BLOCK    = 4'd9;
    localparam logic [3:0] ST_BAD_SEGMENT = 4'd10;

    localparam logic [15:0] VERSION_WORD  = 16'h0200;
    localparam logic [15:0] REVISION_WORD = 16'h0206;
    localparam logic [15:0] QUERY_LARGEST = 16'hFFFF;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_HSCAN, S_URD, S_UEV, S_UEND, S_UDEC,
        S_UTAKE, S_RRD, S_REV, S_RFREE, S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_HSTEP, OP_UEVAL, OP_UCLOSE, OP_UPREP,
        OP_UTAKE, OP_REVAL, OP_RFREE, OP_FINISH
    } dp_op_t;

    typedef struct packed {
        logic [7:0] cmd;
        logic       dx_all;
        logic       h_stop;
        logic       idx_last;
        logic       fit_found;
        logic       take_more;
        logic       r_hit;
        logic       free_more;
        logic       res_free;
    } dp_status_t;

    function automatic logic [PW-1:0] blk_size(input logic [IW-1:0] i,
                                               input logic [UMB_W-1:0] umk);
        logic [LW-1:0] total;
        logic [LW-1:0] start;
        logic [LW-1:0] rem;
        total = LW'(umk) << 6;
        if (total > LW'(CAP_PARAGRAPHS))
            total = LW'(CAP_PARAGRAPHS);
        start = LW'(i) * LW'(BLOCK_PARAGRAPHS);
        rem   = total - start;
        if (total <= start)
            return '0;
        else if (rem < LW'(BLOCK_PARAGRAPHS))
            return PW'(rem);
        else
            return PW'(BLOCK_PARAGRAPHS);
    endfunction

    function automatic logic [15:0] blk_seg(input logic [IW-1:0] i);
        logic [31:0] s;
        s = 32'(UPPER_BASE_SEGMENT) + 32'(i) * 32'(BLOCK_PARAGRAPHS);
        return s[15:0];
    endfunction

    function automatic logic [15:0] sat16(input logic [PW-1:0] v);
        if (32'(v) > 32'hFFFF)
            return 16'hFFFF;
        else
            return 16'(v);
    endfunction

endpackage

[hdl/xmm_if.sv]
// ----------------------------------------------------------------------------
// xmm_in_if / xmm_out_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface xmm_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  cmd;
    logic [15:0] dx_in;
    modport source (output valid, output cmd, output dx_in, input ready);
    modport sink   (input valid, input cmd, input dx_in, output ready);
endinterface

interface xmm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] ax_value;
    logic [15:0] bx_value;
    logic        bx_written;
    logic [15:0] dx_value;
    logic        dx_written;
    logic [3:0]  status;
    logic        status_written;
    modport source (output valid, output ax_value, output bx_value, output bx_written,
                    output dx_value, output dx_written, output status,
                    output status_written, input ready);
    modport sink   (input valid, input ax_value, input bx_value, input bx_written,
                    input dx_value, input dx_written, input status,
                    input status_written, output ready);
endinterface

[hdl/xms_memory_manager.sv]
// ----------------------------------------------------------------------------
// xms_memory_manager
// Extended and upper memory manager: one driver request per transaction.
//
//   channel   dir  handshake        payload
//   in_ch     in   valid/ready      cmd, dx_in
//   out_ch    out  valid/ready      ax/bx/dx values, write marks, status
//   cfg       in   cfg_we           cfg_index, cfg_data
//
// Allocate scans the handle table for a free handle; an upper block request
// scans all 96 table entries, then marks the blocks taken on a fit; release
// scans the entries up to the matching head, then frees the blocks on a hit.
// Reset and each write to the XMS limit or upper memory size clear all
// allocations at once. A result waits in the output register; the next
// request is accepted, but its result waits until that register is free.
// ----------------------------------------------------------------------------
module xms_memory_manager (
    input  logic                      clk,
    input  logic                      rst_n,
    xmm_in_if.sink                    in_ch,
    xmm_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [xmm_pkg::CFG_W-1:0] cfg_data
);

    xmm_pkg::dp_op_t     op;
    xmm_pkg::dp_status_t st;

    xmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .op       (op)
    );

    xmm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .st             (st),
        .in_cmd         (in_ch.cmd),
        .in_dx          (in_ch.dx_in),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .ax_value       (out_ch.ax_value),
        .bx_value       (out_ch.bx_value),
        .bx_written     (out_ch.bx_written),
        .dx_value       (out_ch.dx_value),
        .dx_written     (out_ch.dx_written),
        .status         (out_ch.status),
        .status_written (out_ch.status_written)
    );

endmodule

[hdl/xmm_ram.sv]
// ----------------------------------------------------------------------------
// xmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/xmm_ctrl.sv]
// ----------------------------------------------------------------------------
// xmm_ctrl
// Sequencer: decodes the request and steps the datapath through scans.
// ----------------------------------------------------------------------------
module xmm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  xmm_pkg::dp_status_t st,
    output xmm_pkg::dp_op_t    op
);

    xmm_pkg::state_t state_reg;
    xmm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xmm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            xmm_pkg::S_IDLE:
                if (in_valid)
                    state_next = xmm_pkg::S_DISPATCH;
            xmm_pkg::S_DISPATCH:
                if (st.cmd == xmm_pkg::CMD_ALLOC)
                    state_next = xmm_pkg::S_HSCAN;
                else if (st.cmd == xmm_pkg::CMD_UMB_REQ)
                    state_next = xmm_pkg::S_URD;
                else if (st.cmd == xmm_pkg::CMD_UMB_REL)
                    state_next = xmm_pkg::S_RRD;
                else
                    state_next = xmm_pkg::S_FINISH;
            xmm_pkg::S_HSCAN:
                if (st.h_stop)
                    state_next = xmm_pkg::S_FINISH;
            xmm_pkg::S_URD:
                state_next = xmm_pkg::S_UEV;
            xmm_pkg::S_UEV:
                state_next = st.idx_last ? xmm_pkg::S_UEND : xmm_pkg::S_URD;
            xmm_pkg::S_UEND:
                state_next = xmm_pkg::S_UDEC;
            xmm_pkg::S_UDEC:
                state_next = (!st.dx_all && st.fit_found) ? xmm_pkg::S_UTAKE
                                                          : xmm_pkg::S_FINISH;
            xmm_pkg::S_UTAKE:
                if (!st.take_more)
                    state_next = xmm_pkg::S_FINISH;
            xmm_pkg::S_RRD:
                state_next = xmm_pkg::S_REV;
            xmm_pkg::S_REV:
                if (st.r_hit)
                    state_next = xmm_pkg::S_RFREE;
                else if (st.idx_last)
                    state_next = xmm_pkg::S_FINISH;
                else
                    state_next = xmm_pkg::S_RRD;
            xmm_pkg::S_RFREE:
                if (!st.free_more)
                    state_next = xmm_pkg::S_FINISH;
            xmm_pkg::S_FINISH:
                if (st.res_free)
                    state_next = xmm_pkg::S_IDLE;
            default:
                state_next = xmm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        op       = xmm_pkg::OP_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            xmm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    op = xmm_pkg::OP_LOAD;
            end
            xmm_pkg::S_HSCAN:
                if (!st.h_stop)
                    op = xmm_pkg::OP_HSTEP;
            xmm_pkg::S_UEV:
                op = xmm_pkg::OP_UEVAL;
            xmm_pkg::S_UEND:
                op = xmm_pkg::OP_UCLOSE;
            xmm_pkg::S_UDEC:
                op = xmm_pkg::OP_UPREP;
            xmm_pkg::S_UTAKE:
                if (st.take_more)
                    op = xmm_pkg::OP_UTAKE;
            xmm_pkg::S_REV:
                op = xmm_pkg::OP_REVAL;
            xmm_pkg::S_RFREE:
                if (st.free_more)
                    op = xmm_pkg::OP_RFREE;
            xmm_pkg::S_FINISH:
                if (st.res_free)
                    op = xmm_pkg::OP_FINISH;
            default:
                op = xmm_pkg::OP_NONE;
        endcase
    end

endmodule

[hdl/xmm_dp.sv]
// ----------------------------------------------------------------------------
// xmm_dp
// Datapath: manager state, handle and upper block tables, result register.
// ----------------------------------------------------------------------------
module xmm_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  xmm_pkg::dp_op_t             op,
    output xmm_pkg::dp_status_t         st,
    input  logic [7:0]                  in_cmd,
    input  logic [15:0]                 in_dx,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [xmm_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [15:0]                 ax_value,
    output logic [15:0]                 bx_value,
    output logic                        bx_written,
    output logic [15:0]                 dx_value,
    output logic                        dx_written,
    output logic [3:0]                  status,
    output logic                        status_written
);

    localparam int HC = xmm_pkg::HANDLE_COUNT;
    localparam int UB = xmm_pkg::UPPER_BLOCKS;
    localparam int HW = xmm_pkg::HW;
    localparam int UW = xmm_pkg::UW;
    localparam int IW = xmm_pkg::IW;
    localparam int PW = xmm_pkg::PW;
    localparam int MW = xmm_pkg::MW;
    localparam int KW = xmm_pkg::KW;

    logic [xmm_pkg::XMS_W-1:0] xms_reg, xms_next;
    logic [xmm_pkg::UMB_W-1:0] umk_reg, umk_next;
    logic                      a20_reg, a20_next;
    logic                      hma_reg, hma_next;
    logic [KW-1:0]             total_reg, total_next;
    logic [7:0]                cmd_reg, cmd_next;
    logic [15:0]               dx_reg, dx_next;
    logic [IW-1:0]             idx_reg, idx_next;
    logic                      hused_reg [HC];
    logic                      hused_next [HC];
    logic                      uvalid_reg [UB];
    logic                      uvalid_next [UB];
    logic                      in_run_reg, in_run_next;
    logic [PW-1:0]             run_reg, run_next;
    logic [UW-1:0]             head_reg, head_next;
    logic                      fit_reg, fit_next;
    logic [PW-1:0]             fit_len_reg, fit_len_next;
    logic [UW-1:0]             fit_head_reg, fit_head_next;
    logic [PW-1:0]             big_len_reg, big_len_next;
    logic [UW-1:0]             big_head_reg, big_head_next;
    logic [15:0]               rem_reg, rem_next;
    logic [PW-1:0]             tot_reg, tot_next;
    logic [MW-1:0]             par_reg, par_next;
    logic                      rdone_reg, rdone_next;

    logic                      res_valid_reg, res_valid_next;
    logic [15:0]               ax_reg, ax_next;
    logic [15:0]               bx_reg, bx_next;
    logic                      bxw_reg, bxw_next;
    logic [15:0]               dxo_reg, dxo_next;
    logic                      dxw_reg, dxw_next;
    logic [3:0]                st_reg, st_next;
    logic                      stw_reg, stw_next;

    logic                      hram_we;
    logic [15:0]               hram_rdata;
    logic                      uram_we;
    logic [UW-1:0]             uram_waddr;
    logic [MW-1:0]             uram_wdata;
    logic [MW-1:0]             uram_rdata;

    logic [HW-1:0]             hi;
    logic [UW-1:0]             ui;
    logic [MW-1:0]             mark;
    logic [PW-1:0]             sz;
    logic [15:0]               seg_cur;
    logic [KW-1:0]             lim;
    logic [KW:0]               used;
    logic [KW-1:0]             free_kb;
    logic                      h_found;
    logic                      alloc_ok;
    logic                      hrel_ok;
    logic                      r_hit;
    logic                      take_more;
    logic                      free_more;
    logic                      close_en;
    logic [PW-1:0]             close_run;
    logic [UW-1:0]             close_head;

    assign hi      = idx_reg[HW-1:0];
    assign ui      = idx_reg[UW-1:0];
    assign mark    = uvalid_reg[ui] ? uram_rdata : '0;
    assign sz      = xmm_pkg::blk_size(idx_reg, umk_reg);
    assign seg_cur = xmm_pkg::blk_seg(idx_reg);

    assign lim     = (32'(xms_reg) > 32'(xmm_pkg::MAX_XMS_KB)) ? KW'(xmm_pkg::MAX_XMS_KB)
                                                                : KW'(xms_reg);
    assign used    = (KW+1)'(total_reg) + (hma_reg ? (KW+1)'(xmm_pkg::HMA_KB) : '0);
    assign free_kb = (used < (KW+1)'(lim)) ? KW'((KW+1)'(lim) - used) : '0;

    assign h_found  = idx_reg != IW'(HC);
    assign alloc_ok = h_found && (dx_reg != '0) && (dx_reg <= 16'(free_kb));
    assign hrel_ok  = (dx_reg != '0) && (32'(dx_reg) < 32'(HC)) && hused_reg[dx_reg[HW-1:0]];
    assign r_hit    = (seg_cur == dx_reg) && (mark != '0) && (mark != xmm_pkg::MARK_CHAIN);
    assign take_more = (rem_reg != '0) && (idx_reg < IW'(UB));
    assign free_more = (par_reg != '0) && (idx_reg < IW'(UB));

    assign st.cmd       = cmd_reg;
    assign st.dx_all    = dx_reg == xmm_pkg::QUERY_LARGEST;
    assign st.h_stop    = !h_found || !hused_reg[hi];
    assign st.idx_last  = idx_reg == IW'(UB - 1);
    assign st.fit_found = fit_reg;
    assign st.take_more = take_more;
    assign st.r_hit     = r_hit;
    assign st.free_more = free_more;
    assign st.res_free  = !res_valid_reg || out_ready;

    assign hram_we    = (op == xmm_pkg::OP_FINISH) && (cmd_reg == xmm_pkg::CMD_ALLOC) && alloc_ok;
    assign uram_we    = ((op == xmm_pkg::OP_UTAKE) && take_more) ||
                        ((op == xmm_pkg::OP_FINISH) && (cmd_reg == xmm_pkg::CMD_UMB_REQ) &&
                         !st.dx_all && fit_reg);
    assign uram_waddr = (op == xmm_pkg::OP_UTAKE) ? ui : fit_head_reg;
    assign uram_wdata = (op == xmm_pkg::OP_UTAKE) ? xmm_pkg::MARK_CHAIN : MW'(tot_reg);

    xmm_ram #(.WIDTH(16), .DEPTH(HC)) u_hram (
        .clk   (clk),
        .we    (hram_we),
        .waddr (hi),
        .wdata (dx_reg),
        .raddr (dx_reg[HW-1:0]),
        .rdata (hram_rdata)
    );

    xmm_ram #(.WIDTH(MW), .DEPTH(UB)) u_uram (
        .clk   (clk),
        .we    (uram_we),
        .waddr (uram_waddr),
        .wdata (uram_wdata),
        .raddr (ui),
        .rdata (uram_rdata)
    );

    always_comb
    begin
        xms_next       = xms_reg;
        umk_next       = umk_reg;
        a20_next       = a20_reg;
        hma_next       = hma_reg;
        total_next     = total_reg;
        cmd_next       = cmd_reg;
        dx_next        = dx_reg;
        idx_next       = idx_reg;
        hused_next     = hused_reg;
        uvalid_next    = uvalid_reg;
        in_run_next    = in_run_reg;
        run_next       = run_reg;
        head_next      = head_reg;
        fit_next       = fit_reg;
        fit_len_next   = fit_len_reg;
        fit_head_next  = fit_head_reg;
        big_len_next   = big_len_reg;
        big_head_next  = big_head_reg;
        rem_next       = rem_reg;
        tot_next       = tot_reg;
        par_next       = par_reg;
        rdone_next     = rdone_reg;
        res_valid_next = res_valid_reg;
        ax_next        = ax_reg;
        bx_next        = bx_reg;
        bxw_next       = bxw_reg;
        dxo_next       = dxo_reg;
        dxw_next       = dxw_reg;
        st_next        = st_reg;
        stw_next       = stw_reg;
        close_en       = 1'b0;
        close_run      = run_reg;
        close_head     = head_reg;

        if (out_ready)
            res_valid_next = 1'b0;

        case (op)
            xmm_pkg::OP_LOAD:
            begin
                cmd_next     = in_cmd;
                dx_next      = in_dx;
                idx_next     = (in_cmd == xmm_pkg::CMD_ALLOC) ? IW'(1) : '0;
                in_run_next  = 1'b0;
                fit_next     = 1'b0;
                big_len_next = '0;
                tot_next     = '0;
                rdone_next   = 1'b0;
            end
            xmm_pkg::OP_HSTEP:
                idx_next = idx_reg + IW'(1);
            xmm_pkg::OP_UEVAL:
            begin
                if ((mark == '0) && (sz != '0))
                begin
                    in_run_next = 1'b1;
                    if (in_run_reg)
                        run_next = run_reg + sz;
                    else
                    begin
                        run_next  = sz;
                        head_next = ui;
                    end
                end
                else if (in_run_reg)
                begin
                    close_en    = 1'b1;
                    in_run_next = 1'b0;
                end
                idx_next = idx_reg + IW'(1);
            end
            xmm_pkg::OP_UCLOSE:
            begin
                close_en    = in_run_reg;
                in_run_next = 1'b0;
            end
            xmm_pkg::OP_UPREP:
            begin
                idx_next = IW'(fit_head_reg);
                rem_next = dx_reg;
            end
            xmm_pkg::OP_UTAKE:
            begin
                uvalid_next[ui] = 1'b1;
                tot_next        = tot_reg + sz;
                rem_next        = (32'(rem_reg) > 32'(sz)) ? 16'(32'(rem_reg) - 32'(sz)) : '0;
                idx_next        = idx_reg + IW'(1);
            end
            xmm_pkg::OP_REVAL:
                if (r_hit)
                begin
                    par_next   = mark;
                    rdone_next = 1'b1;
                end
                else
                    idx_next = idx_reg + IW'(1);
            xmm_pkg::OP_RFREE:
            begin
                uvalid_next[ui] = 1'b0;
                par_next        = (32'(par_reg) > 32'(sz)) ? MW'(32'(par_reg) - 32'(sz)) : '0;
                idx_next        = idx_reg + IW'(1);
            end
            xmm_pkg::OP_FINISH:
            begin
                res_valid_next = 1'b1;
                ax_next  = '0;
                bx_next  = '0;
                bxw_next = 1'b0;
                dxo_next = '0;
                dxw_next = 1'b0;
                st_next  = xmm_pkg::ST_OK;
                stw_next = 1'b1;
                case (cmd_reg)
                    xmm_pkg::CMD_VERSION:
                    begin
                        ax_next  = xmm_pkg::VERSION_WORD;
                        bx_next  = xmm_pkg::REVISION_WORD;
                        bxw_next = 1'b1;
                        dxo_next = (32'(lim) >= 32'(xmm_pkg::HMA_KB)) ? 16'd1 : 16'd0;
                        dxw_next = 1'b1;
                        stw_next = 1'b0;
                    end
                    xmm_pkg::CMD_HMA_REQ:
                        if (32'(lim) < 32'(xmm_pkg::HMA_KB))
                            st_next = xmm_pkg::ST_NO_HMA;
                        else if (hma_reg)
                            st_next = xmm_pkg::ST_HMA_USED;
                        else
                        begin
                            hma_next = 1'b1;
                            a20_next = 1'b1;
                            ax_next  = 16'd1;
                        end
                    xmm_pkg::CMD_HMA_REL:
                        if (!hma_reg)
                            st_next = xmm_pkg::ST_HMA_FREE;
                        else
                        begin
                            hma_next = 1'b0;
                            ax_next  = 16'd1;
                        end
                    xmm_pkg::CMD_A20_GON, xmm_pkg::CMD_A20_LON:
                    begin
                        a20_next = 1'b1;
                        ax_next  = 16'd1;
                    end
                    xmm_pkg::CMD_A20_GOFF, xmm_pkg::CMD_A20_LOFF:
                    begin
                        a20_next = 1'b0;
                        ax_next  = 16'd1;
                    end
                    xmm_pkg::CMD_A20_QUERY:
                        ax_next = {15'd0, a20_reg};
                    xmm_pkg::CMD_FREE_QUERY:
                    begin
                        ax_next  = 16'(free_kb);
                        dxo_next = 16'(free_kb);
                        dxw_next = 1'b1;
                    end
                    xmm_pkg::CMD_ALLOC:
                        if (alloc_ok)
                        begin
                            hused_next[hi] = 1'b1;
                            total_next     = total_reg + KW'(dx_reg);
                            dxo_next       = 16'(idx_reg);
                            dxw_next       = 1'b1;
                            ax_next        = 16'd1;
                        end
                        else
                            st_next = h_found ? xmm_pkg::ST_NO_MEMORY : xmm_pkg::ST_NO_HANDLE;
                    xmm_pkg::CMD_FREE_HANDLE:
                        if (hrel_ok)
                        begin
                            hused_next[dx_reg[HW-1:0]] = 1'b0;
                            total_next = total_reg - KW'(hram_rdata);
                            ax_next    = 16'd1;
                        end
                        else
                            st_next = xmm_pkg::ST_BAD_HANDLE;
                    xmm_pkg::CMD_UMB_REQ:
                        if (st.dx_all && (big_len_reg != '0))
                        begin
                            ax_next  = 16'd1;
                            bx_next  = xmm_pkg::blk_seg(IW'(big_head_reg));
                            bxw_next = 1'b1;
                            dxo_next = xmm_pkg::sat16(big_len_reg);
                            dxw_next = 1'b1;
                            stw_next = 1'b0;
                        end
                        else if (!st.dx_all && fit_reg)
                        begin
                            uvalid_next[fit_head_reg] = 1'b1;
                            ax_next  = 16'd1;
                            bx_next  = xmm_pkg::blk_seg(IW'(fit_head_reg));
                            bxw_next = 1'b1;
                            dxo_next = xmm_pkg::sat16(tot_reg);
                            dxw_next = 1'b1;
                            stw_next = 1'b0;
                        end
                        else
                        begin
                            dxo_next = xmm_pkg::sat16(big_len_reg);
                            dxw_next = 1'b1;
                            st_next  = (big_len_reg == '0) ? xmm_pkg::ST_NO_BLOCK
                                                           : xmm_pkg::ST_SMALLER;
                        end
                    xmm_pkg::CMD_UMB_REL:
                        if (rdone_reg)
                            ax_next = 16'd1;
                        else
                        begin
                            dxw_next = 1'b1;
                            st_next  = xmm_pkg::ST_BAD_SEGMENT;
                        end
                    default:
                        st_next = xmm_pkg::ST_UNSUPPORTED;
                endcase
            end
            default:
            begin
            end
        endcase

        if (close_en)
        begin
            if ((32'(close_run) >= 32'(dx_reg)) && (!fit_reg || (close_run < fit_len_reg)))
            begin
                fit_next      = 1'b1;
                fit_len_next  = close_run;
                fit_head_next = close_head;
            end
            if (close_run > big_len_reg)
            begin
                big_len_next  = close_run;
                big_head_next = close_head;
            end
        end

        if (cfg_we && ((cfg_index == xmm_pkg::CFG_XMS_LIMIT) ||
                       (cfg_index == xmm_pkg::CFG_UPPER_KB)))
        begin
            if (cfg_index == xmm_pkg::CFG_XMS_LIMIT)
                xms_next = cfg_data[xmm_pkg::XMS_W-1:0];
            else
                umk_next = cfg_data[xmm_pkg::UMB_W-1:0];
            hma_next   = 1'b0;
            total_next = '0;
            for (int h = 0; h < HC; h++)
                hused_next[h] = 1'b0;
            for (int u = 0; u < UB; u++)
                uvalid_next[u] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xms_reg       <= xmm_pkg::XMS_RESET;
            umk_reg       <= xmm_pkg::UMB_RESET;
            a20_reg       <= 1'b0;
            hma_reg       <= 1'b0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int h = 0; h < HC; h++)
                hused_reg[h] <= 1'b0;
            for (int u = 0; u < UB; u++)
                uvalid_reg[u] <= 1'b0;
        end
        else
        begin
            xms_reg       <= xms_next;
            umk_reg       <= umk_next;
            a20_reg       <= a20_next;
            hma_reg       <= hma_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
            hused_reg     <= hused_next;
            uvalid_reg    <= uvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        dx_reg       <= dx_next;
        idx_reg      <= idx_next;
        in_run_reg   <= in_run_next;
        run_reg      <= run_next;
        head_reg     <= head_next;
        fit_reg      <= fit_next;
        fit_len_reg  <= fit_len_next;
        fit_head_reg <= fit_head_next;
        big_len_reg  <= big_len_next;
        big_head_reg <= big_head_next;
        rem_reg      <= rem_next;
        tot_reg      <= tot_next;
        par_reg      <= par_next;
        rdone_reg    <= rdone_next;
        ax_reg       <= ax_next;
        bx_reg       <= bx_next;
        bxw_reg      <= bxw_next;
        dxo_reg      <= dxo_next;
        dxw_reg      <= dxw_next;
        st_reg       <= st_next;
        stw_reg      <= stw_next;
    end

    assign out_valid      = res_valid_reg;
    assign ax_value       = ax_reg;
    assign bx_value       = bx_reg;
    assign bx_written     = bxw_reg;
    assign dx_value       = dxo_reg;
    assign dx_written     = dxw_reg;
    assign status         = st_reg;
    assign status_written = stw_reg;

endmodule

[tb/xms_memory_manager_tb.sv]
// ----------------------------------------------------------------------------
// xms_memory_manager_tb
// Drives driver requests with random gaps and result stalls, predicts every
// result from a model of the manager state, and compares every field.
// Covers a directed table, configuration phases and constrained random calls.
// ----------------------------------------------------------------------------
module xms_memory_manager_tb;

    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] bx;
        logic        bxw;
        logic [15:0] dx;
        logic        dxw;
        logic [3:0]  st;
        logic        stw;
    } answer_t;

    typedef struct {
        logic [7:0]  cmd;
        logic [15:0] dx;
        logic        chk;
        answer_t     ans;
    } row_t;

    localparam int LIMIT_CYCLES = 3000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [xmm_pkg::CFG_W-1:0] cfg_data;

    xmm_in_if  in_ch ();
    xmm_out_if out_ch ();

    xms_memory_manager uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model state
    int          m_limit;
    int          m_umk;
    bit          m_a20;
    bit          m_hma;
    int          m_hsize [xmm_pkg::HANDLE_COUNT];
    int          m_total;
    longint      m_mark [xmm_pkg::UPPER_BLOCKS];
    localparam longint M_FREE  = 0;
    localparam longint M_OFF   = -1;
    localparam longint M_CHAIN = -2;

    answer_t     pending_answers [$];
    logic [15:0] taken_segs [$];
    int          errors;
    int          cycles;
    bit          idle_off;
    bit          stall_on;

    function automatic int lim_kb();
        return m_limit > xmm_pkg::MAX_XMS_KB ? xmm_pkg::MAX_XMS_KB : m_limit;
    endfunction

    function automatic int free_kb();
        int used;
        used = m_total + (m_hma ? xmm_pkg::HMA_KB : 0);
        return used < lim_kb() ? lim_kb() - used : 0;
    endfunction

    function automatic int bsize(int i);
        int total;
        total = m_umk * 64;
        if (total > xmm_pkg::CAP_PARAGRAPHS) total = xmm_pkg::CAP_PARAGRAPHS;
        if (total <= i * xmm_pkg::BLOCK_PARAGRAPHS) return 0;
        total = total - i * xmm_pkg::BLOCK_PARAGRAPHS;
        return total < xmm_pkg::BLOCK_PARAGRAPHS ? total : xmm_pkg::BLOCK_PARAGRAPHS;
    endfunction

    function automatic logic [15:0] bseg(int i);
        return 16'(xmm_pkg::UPPER_BASE_SEGMENT + i * xmm_pkg::BLOCK_PARAGRAPHS);
    endfunction

    function automatic logic [15:0] sat(int v);
        return v > 65535 ? 16'hFFFF : 16'(v);
    endfunction

    task automatic clear_state();
        for (int i = 0; i < xmm_pkg::UPPER_BLOCKS; i++)
            m_mark[i] = bsize(i) != 0 ? M_FREE : M_OFF;
        for (int i = 0; i < xmm_pkg::HANDLE_COUNT; i++)
            m_hsize[i] = 0;
        m_total = 0;
        m_hma = 0;
        taken_segs.delete();
    endtask

    function automatic int find_run(bit fit, int need, output int len);
        int best, i, j, run;
        best = -1;
        len = 0;
        i = 0;
        while (i < xmm_pkg::UPPER_BLOCKS) begin
            if (m_mark[i] != M_FREE) begin
                i++;
                continue;
            end
            j = i;
            run = 0;
            while (j < xmm_pkg::UPPER_BLOCKS && m_mark[j] == M_FREE) begin
                run += bsize(j);
                j++;
            end
            if (fit) begin
                if (run >= need && (best < 0 || run < len)) begin
                    best = i;
                    len = run;
                end
            end else if (run > len) begin
                best = i;
                len = run;
            end
            i = j;
        end
        return best;
    endfunction

    function automatic answer_t serve_request(logic [7:0] cmd, logic [15:0] dx);
        answer_t a;
        int h, len, head, rem, tot, k, par;
        bit done;
        a = '0;
        a.stw = 1;
        case (cmd)
            xmm_pkg::CMD_VERSION: begin
                a.ax = xmm_pkg::VERSION_WORD; a.bx = xmm_pkg::REVISION_WORD; a.bxw = 1;
                a.dx = 16'(lim_kb() >= xmm_pkg::HMA_KB); a.dxw = 1; a.stw = 0;
            end
            xmm_pkg::CMD_HMA_REQ: begin
                if (lim_kb() < xmm_pkg::HMA_KB) a.st = xmm_pkg::ST_NO_HMA;
                else if (m_hma) a.st = xmm_pkg::ST_HMA_USED;
                else begin m_hma = 1; m_a20 = 1; a.ax = 1; end
            end
            xmm_pkg::CMD_HMA_REL: begin
                if (!m_hma) a.st = xmm_pkg::ST_HMA_FREE;
                else begin m_hma = 0; a.ax = 1; end
            end
            xmm_pkg::CMD_A20_GON, xmm_pkg::CMD_A20_LON: begin m_a20 = 1; a.ax = 1; end
            xmm_pkg::CMD_A20_GOFF, xmm_pkg::CMD_A20_LOFF: begin m_a20 = 0; a.ax = 1; end
            xmm_pkg::CMD_A20_QUERY: a.ax = {15'd0, m_a20};
            xmm_pkg::CMD_FREE_QUERY: begin
                a.ax = sat(free_kb()); a.dx = a.ax; a.dxw = 1;
            end
            xmm_pkg::CMD_ALLOC: begin
                h = 0;
                for (int i = 1; i < xmm_pkg::HANDLE_COUNT; i++)
                    if (h == 0 && m_hsize[i] == 0) h = i;
                if (dx > 0 && h != 0 && dx <= free_kb()) begin
                    m_hsize[h] = dx; m_total += dx;
                    a.dx = 16'(h); a.dxw = 1; a.ax = 1;
                end else
                    a.st = h != 0 ? xmm_pkg::ST_NO_MEMORY : xmm_pkg::ST_NO_HANDLE;
            end
            xmm_pkg::CMD_FREE_HANDLE: begin
                if (dx > 0 && dx < xmm_pkg::HANDLE_COUNT && m_hsize[dx] != 0) begin
                    m_total -= m_hsize[dx]; m_hsize[dx] = 0; a.ax = 1;
                end else
                    a.st = xmm_pkg::ST_BAD_HANDLE;
            end
            xmm_pkg::CMD_UMB_REQ: begin
                done = 0;
                if (dx == xmm_pkg::QUERY_LARGEST) begin
                    head = find_run(0, 0, len);
                    if (head >= 0) begin
                        a.ax = 1; a.bx = bseg(head); a.bxw = 1;
                        a.dx = sat(len); a.dxw = 1; a.stw = 0; done = 1;
                    end
                end else begin
                    head = find_run(1, dx, len);
                    if (head >= 0) begin
                        rem = dx; tot = 0; k = head;
                        while (rem > 0 && k < xmm_pkg::UPPER_BLOCKS) begin
                            tot += bsize(k);
                            m_mark[k] = M_CHAIN;
                            rem = rem > bsize(k) ? rem - bsize(k) : 0;
                            k++;
                        end
                        m_mark[head] = tot;
                        if (tot > 0) taken_segs.push_back(bseg(head));
                        a.ax = 1; a.bx = bseg(head); a.bxw = 1;
                        a.dx = sat(tot); a.dxw = 1; a.stw = 0; done = 1;
                    end
                end
                if (!done) begin
                    head = find_run(0, 0, len);
                    a.dx = sat(len); a.dxw = 1;
                    a.st = len == 0 ? xmm_pkg::ST_NO_BLOCK : xmm_pkg::ST_SMALLER;
                end
            end
            xmm_pkg::CMD_UMB_REL: begin
                done = 0;
                for (int i = 0; i < xmm_pkg::UPPER_BLOCKS; i++) begin
                    if (!done && bseg(i) == dx && m_mark[i] != M_FREE &&
                        m_mark[i] != M_OFF && m_mark[i] != M_CHAIN) begin
                        par = int'(m_mark[i]); k = i;
                        while (par > 0 && k < xmm_pkg::UPPER_BLOCKS) begin
                            m_mark[k] = M_FREE;
                            par = par > bsize(k) ? par - bsize(k) : 0;
                            k++;
                        end
                        a.ax = 1; done = 1;
                    end
                end
                if (!done) begin a.dxw = 1; a.st = xmm_pkg::ST_BAD_SEGMENT; end
            end
            default: a.st = xmm_pkg::ST_UNSUPPORTED;
        endcase
        return a;
    endfunction

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result sink
    always @(posedge clk)
    begin
        answer_t got, want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.ax_value, out_ch.bx_value, out_ch.bx_written,
                       out_ch.dx_value, out_ch.dx_written, out_ch.status,
                       out_ch.status_written};
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: ax exp %h got %h, bx exp %h/%b got %h/%b",
                                 $time, want.ax, got.ax, want.bx, want.bxw,
                                 got.bx, got.bxw);
                        $display("%0t: dx exp %h/%b got %h/%b, st exp %0d/%b got %0d/%b",
                                 $time, want.dx, want.dxw, got.dx, got.dxw,
                                 want.st, want.stw, got.st, got.stw);
                        errors++;
                    end
                end
            end
            out_ch.ready <= stall_on ? ($urandom_range(99) >= 18) : 1'b1;
        end
    end

    task automatic send(logic [7:0] cmd, logic [15:0] dx, bit chk, answer_t ans);
        answer_t a;
        while (!idle_off && $urandom_range(99) < 18)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid <= 1;
        in_ch.cmd   <= cmd;
        in_ch.dx_in <= dx;
        a = serve_request(cmd, dx);
        if (chk && a !== ans)
        begin
            $display("%0t: table row cmd %h exp %h predicted %h", $time, cmd, ans, a);
            errors++;
        end
        pending_answers.push_back(a);
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic write_cfg(logic [1:0] idx, int val);
        in_ch.valid <= 0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= xmm_pkg::CFG_W'(val);
        @(posedge clk);
        cfg_we <= 0;
        if (idx == xmm_pkg::CFG_XMS_LIMIT) m_limit = val;
        else m_umk = val & 8'hFF;
        clear_state();
    endtask

    function automatic answer_t mk(logic [15:0] ax, logic [15:0] bx, logic bxw,
                                   logic [15:0] dx, logic dxw, logic [3:0] st,
                                   logic stw);
        return {ax, bx, bxw, dx, dxw, st, stw};
    endfunction

    task automatic random_item(int mode);
        logic [7:0]  c;
        logic [15:0] d;
        int r;
        r = $urandom_range(99);
        d = 16'($urandom);
        if (r < 8) c = 8'($urandom);
        else if (r < 25) begin
            c = xmm_pkg::CMD_ALLOC;
            d = 16'($urandom_range(mode ? 600 : 200, 0));
        end
        else if (r < 37) begin
            c = xmm_pkg::CMD_FREE_HANDLE;
            d = 16'($urandom_range(66));
        end
        else if (r < 57) begin
            c = xmm_pkg::CMD_UMB_REQ;
            case ($urandom_range(5))
                0: d = xmm_pkg::QUERY_LARGEST;
                1: d = 0;
                2: d = 16'($urandom);
                default: d = 16'($urandom_range(700, 1));
            endcase
        end
        else if (r < 72) begin
            c = xmm_pkg::CMD_UMB_REL;
            if (taken_segs.size() != 0 && $urandom_range(3) != 0)
                d = taken_segs[$urandom_range(taken_segs.size() - 1)];
            else if ($urandom_range(1))
                d = bseg($urandom_range(xmm_pkg::UPPER_BLOCKS - 1));
        end
        else c = 8'($urandom_range(8));
        send(c, d, 0, '0);
    endtask

    row_t rows [$];

    initial
    begin
        int cfg_lims [5];
        int cfg_umbs [5];
        errors = 0;
        cycles = 0;
        idle_off = 0;
        stall_on = 1;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = xmm_pkg::CFG_XMS_LIMIT;
        cfg_data = '0;
        in_ch.valid = 0;
        in_ch.cmd = '0;
        in_ch.dx_in = '0;
        out_ch.ready = 0;
        m_limit = xmm_pkg::XMS_RESET;
        m_umk = xmm_pkg::UMB_RESET;
        m_a20 = 0;
        clear_state();
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        rows = '{
            '{xmm_pkg::CMD_VERSION, 16'h0, 1,
              mk(xmm_pkg::VERSION_WORD, xmm_pkg::REVISION_WORD, 1, 1, 1, 0, 0)},
            '{xmm_pkg::CMD_A20_QUERY, 16'h0, 1, mk(0, 0, 0, 0, 0, xmm_pkg::ST_OK, 1)},
            '{xmm_pkg::CMD_FREE_QUERY, 16'h0, 1, mk(8192, 0, 0, 8192, 1, xmm_pkg::ST_OK, 1)},
            '{xmm_pkg::CMD_HMA_REL, 16'h0, 1, mk(0, 0, 0, 0, 0, xmm_pkg::ST_HMA_FREE, 1)},
            '{xmm_pkg::CMD_HMA_REQ, 16'h0, 1, mk(1, 0, 0, 0, 0, xmm_pkg::ST_OK, 1)},
            '{xmm_pkg::CMD_HMA_REQ, 16'h0, 1, mk(0, 0, 0, 0, 0, xmm_pkg::ST_HMA_USED, 1)},
            '{xmm_pkg::CMD_A20_QUERY, 16'h0, 1, mk(1, 0, 0, 0, 0, xmm_pkg::ST_OK, 1)},
            '{xmm_pkg::CMD_A20_GOFF, 16'h0, 0, '0},
            '{xmm_pkg::CMD_A20_LON, 16'h0, 0, '0},
            '{xmm_pkg::CMD_A20_LOFF, 16'h0, 0, '0},
            '{xmm_pkg::CMD_A20_GON, 16'h0, 0, '0},
            '{xmm_pkg::CMD_ALLOC, 16'h0, 1, mk(0, 0, 0, 0, 0, xmm_pkg::ST_NO_MEMORY, 1)},
            '{xmm_pkg::CMD_ALLOC, 16'hFFFF, 1, mk(0, 0, 0, 0, 0, xmm_pkg::ST_NO_MEMORY, 1)},
            '{xmm_pkg::CMD_ALLOC, 16'd100, 1, mk(1, 0, 0, 1, 1, xmm_pkg::ST_OK, 1)},
            '{xmm_pkg::CMD_FREE_HANDLE, 16'h0, 1,
              mk(0, 0, 0, 0, 0, xmm_pkg::ST_BAD_HANDLE, 1)},
            '{xmm_pkg::CMD_FREE_HANDLE, 16'd64, 1,
              mk(0, 0, 0, 0, 0, xmm_pkg::ST_BAD_HANDLE, 1)},
            '{xmm_pkg::CMD_FREE_HANDLE, 16'd1, 1, mk(1, 0, 0, 0, 0, xmm_pkg::ST_OK, 1)},
            '{xmm_pkg::CMD_HMA_REL, 16'h0, 1, mk(1, 0, 0, 0, 0, xmm_pkg::ST_OK, 1)},
            '{xmm_pkg::CMD_UMB_REQ, xmm_pkg::QUERY_LARGEST, 1,
              mk(1, 16'hC000, 1, 12288, 1, 0, 0)},
            '{xmm_pkg::CMD_UMB_REQ, 16'h0, 1, mk(1, 16'hC000, 1, 0, 1, 0, 0)},
            '{xmm_pkg::CMD_UMB_REQ, 16'd13000, 1,
              mk(0, 0, 0, 12288, 1, xmm_pkg::ST_SMALLER, 1)},
            '{xmm_pkg::CMD_UMB_REQ, 16'd200, 1, mk(1, 16'hC000, 1, 256, 1, 0, 0)},
            '{xmm_pkg::CMD_UMB_REL, 16'hC080, 1,
              mk(0, 0, 0, 0, 1, xmm_pkg::ST_BAD_SEGMENT, 1)},
            '{xmm_pkg::CMD_UMB_REL, 16'hC000, 1, mk(1, 0, 0, 0, 0, xmm_pkg::ST_OK, 1)},
            '{8'h0B, 16'h0, 1, mk(0, 0, 0, 0, 0, xmm_pkg::ST_UNSUPPORTED, 1)},
            '{8'hFF, 16'hFFFF, 1, mk(0, 0, 0, 0, 0, xmm_pkg::ST_UNSUPPORTED, 1)}
        };
        foreach (rows[i])
            send(rows[i].cmd, rows[i].dx, rows[i].chk, rows[i].ans);

        // small limits: no HMA, partial last block, empty upper memory
        write_cfg(xmm_pkg::CFG_XMS_LIMIT, 63);
        write_cfg(xmm_pkg::CFG_UPPER_KB, 3);
        send(xmm_pkg::CMD_VERSION, 16'h0, 1,
             mk(xmm_pkg::VERSION_WORD, xmm_pkg::REVISION_WORD, 1, 0, 1, 0, 0));
        send(xmm_pkg::CMD_HMA_REQ, 16'h0, 1, mk(0, 0, 0, 0, 0, xmm_pkg::ST_NO_HMA, 1));
        send(xmm_pkg::CMD_UMB_REQ, xmm_pkg::QUERY_LARGEST, 1,
             mk(1, 16'hC000, 1, 192, 1, 0, 0));
        write_cfg(xmm_pkg::CFG_UPPER_KB, 0);
        send(xmm_pkg::CMD_UMB_REQ, 16'h0, 1, mk(0, 0, 0, 0, 1, xmm_pkg::ST_NO_BLOCK, 1));
        send(xmm_pkg::CMD_UMB_REQ, xmm_pkg::QUERY_LARGEST, 1,
             mk(0, 0, 0, 0, 1, xmm_pkg::ST_NO_BLOCK, 1));
        write_cfg(xmm_pkg::CFG_XMS_LIMIT, 16383);
        send(xmm_pkg::CMD_FREE_QUERY, 16'h0, 1, mk(8192, 0, 0, 8192, 1, xmm_pkg::ST_OK, 1));

        cfg_lims = '{16383, 0, 64, 500, 8192};
        cfg_umbs = '{255, 192, 1, 37, 192};
        for (int p = 0; p < 5; p++)
        begin
            write_cfg(xmm_pkg::CFG_XMS_LIMIT, cfg_lims[p]);
            write_cfg(xmm_pkg::CFG_UPPER_KB, cfg_umbs[p]);
            idle_off = (p == 2);
            stall_on = (p != 2);
            for (int n = 0; n < 190; n++)
                random_item(p == 4);
        end
        idle_off = 0;
        stall_on = 1;
        in_ch.valid <= 0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
